// ===== sv/tfme_pkg.sv =====
// shared types and constants of the topic filter match engine
// no dependencies
package tfme_pkg;
  localparam int SLOTS = 64;
  localparam int CLIENTS = 32;
  localparam int FILTER_LEN = 128;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int POS_W = $clog2(FILTER_LEN);
  localparam int ADDR_W = SLOT_W + POS_W;
  localparam int TOPIC_MAX = 127;

  localparam logic [7:0] CH_MULTI = 8'h23;
  localparam logic [7:0] CH_SINGLE = 8'h2B;
  localparam logic [7:0] CH_LEVEL = 8'h2F;

  localparam logic [1:0] OP_FBYTE = 2'd0;
  localparam logic [1:0] OP_OWNER = 2'd1;
  localparam logic [1:0] OP_TBYTE = 2'd2;
  localparam logic [1:0] OP_TEND = 2'd3;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0, ST_SKIP = 2'd1, ST_HIT = 2'd2, ST_MISS = 2'd3
  } mstat_t;

  typedef enum logic [1:0] {
    SW_NONE, SW_ADV, SW_MASK
  } sweep_t;

  // controller to datapath
  typedef struct packed {
    logic          fwrite;
    logic          owrite;
    logic          load;       // registered read of slot rd_slot's stores
    logic          fetch;      // filter byte read at the slot's cursor
    logic          eval;       // filter byte is back, evaluate the slot
    logic [SLOT_W-1:0] rd_slot;
    sweep_t        kind;       // what the slot data is used for
    logic          clear_mask;
    logic          rearm;
  } ctl_cmd_t;

  typedef struct packed {
    logic again;               // slot needs one more filter byte this step
  } dp_stat_t;
endpackage

// ===== sv/tfme_datapath.sv =====
// filter memory, per-slot cursor and status stores, one slot evaluated at a time
// depends on tfme_pkg
module tfme_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tfme_pkg::ctl_cmd_t    cmd,
  input  logic [tfme_pkg::SLOT_W-1:0] wr_slot,
  input  logic [6:0]            wr_pos,
  input  logic [4:0]            wr_owner,
  input  logic                  wr_en_bit,
  input  logic [7:0]            wr_byte,
  input  logic [7:0]            topic_byte,
  output logic [31:0]           mask,
  output tfme_pkg::dp_stat_t    stat
);
  localparam int SL = tfme_pkg::SLOTS;
  localparam int PW = tfme_pkg::POS_W;

  logic [7:0] fmem [tfme_pkg::SLOTS*tfme_pkg::FILTER_LEN];
  logic [4:0] owner_mem [SL];
  logic [PW-1:0] cur_mem [SL];
  tfme_pkg::mstat_t st_mem [SL];
  logic [SL-1:0] valid_r;
  logic [SL-1:0] fresh_r;   // cursor/status rearmed, reads as zero/running

  // registered reads of the slot under evaluation
  logic [PW-1:0] mcur_r;
  tfme_pkg::mstat_t mst_r;
  logic [4:0] wown_r;
  logic wval_r;
  logic wfresh_r;
  // working cursor and status, filter byte at the working cursor
  logic [PW-1:0] wcur_r;
  tfme_pkg::mstat_t wst_r;
  logic [7:0] fb_r;
  logic [31:0] mask_r;

  logic [PW-1:0] lcur;
  tfme_pkg::mstat_t lst;
  logic [7:0] f;
  logic lvl;
  logic active;
  logic loop;
  logic hit;
  logic [PW-1:0] ncur;
  tfme_pkg::mstat_t nst;
  logic wb;
  logic fb_rd;
  logic [PW-1:0] fb_pos;

  always_comb begin
    lcur = wfresh_r ? '0 : mcur_r;
    lst = wfresh_r ? tfme_pkg::ST_RUN : mst_r;
  end

  // one filter byte per cycle; a skip ended by '/' compares the '/' right away
  always_comb begin
    f = (wcur_r == PW'(tfme_pkg::FILTER_LEN - 1)) ? 8'h00 : fb_r;
    lvl = (topic_byte == tfme_pkg::CH_LEVEL);
    active = (wst_r == tfme_pkg::ST_RUN) || (wst_r == tfme_pkg::ST_SKIP && lvl);
    ncur = wcur_r;
    nst = wst_r;
    loop = 1'b0;
    if (active) begin
      if (f == 8'h00) nst = tfme_pkg::ST_MISS;
      else if (f == tfme_pkg::CH_MULTI) nst = tfme_pkg::ST_HIT;
      else if (f == tfme_pkg::CH_SINGLE) begin
        ncur = wcur_r + 1'b1;
        // a '/' closes the empty level at once, go on with the next filter byte
        if (lvl) begin
          nst = tfme_pkg::ST_RUN;
          loop = 1'b1;
        end else nst = tfme_pkg::ST_SKIP;
      end else if (f != topic_byte) nst = tfme_pkg::ST_MISS;
      else begin
        ncur = wcur_r + 1'b1;
        nst = tfme_pkg::ST_RUN;
      end
    end
    unique case (wst_r)
      tfme_pkg::ST_HIT: hit = 1'b1;
      tfme_pkg::ST_MISS: hit = 1'b0;
      default: hit = (f == 8'h00) || (f == tfme_pkg::CH_MULTI);
    endcase
  end

  assign wb = cmd.eval && cmd.kind == tfme_pkg::SW_ADV && !loop;
  assign stat.again = cmd.eval && cmd.kind == tfme_pkg::SW_ADV && loop;
  assign fb_rd = cmd.fetch || stat.again;
  assign fb_pos = cmd.fetch ? lcur : ncur;

  always_ff @(posedge clk) begin
    if (cmd.fwrite) fmem[{wr_slot, wr_pos[PW-1:0]}] <= wr_byte;
    if (fb_rd) fb_r <= fmem[{cmd.rd_slot, fb_pos}];
  end

  always_ff @(posedge clk) begin
    if (cmd.owrite) owner_mem[wr_slot] <= wr_owner;
    if (cmd.load) begin
      mcur_r <= cur_mem[cmd.rd_slot];
      mst_r <= st_mem[cmd.rd_slot];
      wown_r <= owner_mem[cmd.rd_slot];
      wval_r <= valid_r[cmd.rd_slot];
      wfresh_r <= fresh_r[cmd.rd_slot];
    end
    if (cmd.fetch) begin
      wcur_r <= lcur;
      wst_r <= lst;
    end else if (stat.again) begin
      wcur_r <= ncur;
      wst_r <= nst;
    end
    if (wb) begin
      cur_mem[cmd.rd_slot] <= ncur;
      st_mem[cmd.rd_slot] <= nst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fresh_r <= '1;
    end else begin
      if (cmd.owrite) valid_r[wr_slot] <= wr_en_bit;
      if (wb) fresh_r[cmd.rd_slot] <= 1'b0;
      if (cmd.rearm) fresh_r <= '1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_mask) mask_r <= '0;
    else if (cmd.eval && cmd.kind == tfme_pkg::SW_MASK && wval_r && hit)
      mask_r[wown_r] <= 1'b1;
  end

  assign mask = mask_r;
endmodule

// ===== sv/tfme_ctrl.sv =====
// controller: decodes input items, sequences slot sweeps, holds topic counters
// depends on tfme_pkg
module tfme_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [1:0]         op,
  input  logic [5:0]         slot,
  input  logic [7:0]         byte_in,
  input  tfme_pkg::dp_stat_t stat,
  output logic               busy,
  output tfme_pkg::ctl_cmd_t cmd,
  output logic               done
);
  localparam int SW = tfme_pkg::SLOT_W;
  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_FETCH, S_EVAL, S_DONE} state_t;
  state_t state_r;
  tfme_pkg::sweep_t kind_r;
  logic [SW-1:0] idx_r;
  logic [6:0] tcount_r;
  logic closed_r;
  logic done_r;

  logic slot_ok;
  assign slot_ok = ({26'd0, slot} < 32'(tfme_pkg::SLOTS));

  always_comb begin
    cmd = '0;
    cmd.fwrite = in_fire && op == tfme_pkg::OP_FBYTE && slot_ok;
    cmd.owrite = in_fire && op == tfme_pkg::OP_OWNER && slot_ok;
    cmd.load = state_r == S_LOAD;
    cmd.fetch = state_r == S_FETCH;
    cmd.eval = state_r == S_EVAL;
    cmd.rd_slot = idx_r;
    cmd.kind = kind_r;
    cmd.clear_mask = in_fire && op == tfme_pkg::OP_TEND;
    cmd.rearm = state_r == S_DONE && kind_r == tfme_pkg::SW_MASK;
  end
  // the cycle that hands the mask to the output register counts as busy
  assign busy = state_r != S_IDLE || done_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= tfme_pkg::SW_NONE;
      idx_r <= '0;
      tcount_r <= '0;
      closed_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && op == tfme_pkg::OP_TBYTE && !closed_r) begin
            if (byte_in == 8'h00) closed_r <= 1'b1;
            else if (tcount_r < 7'(tfme_pkg::TOPIC_MAX)) begin
              tcount_r <= tcount_r + 1'b1;
              kind_r <= tfme_pkg::SW_ADV;
              idx_r <= '0;
              state_r <= S_LOAD;
            end
          end else if (in_fire && op == tfme_pkg::OP_TEND) begin
            kind_r <= tfme_pkg::SW_MASK;
            idx_r <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: state_r <= S_FETCH;
        S_FETCH: state_r <= S_EVAL;
        S_EVAL: begin
          // stay while the slot walks over '+' bytes on a '/'
          if (!stat.again) begin
            if (idx_r == SW'(tfme_pkg::SLOTS - 1)) state_r <= S_DONE;
            else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (kind_r == tfme_pkg::SW_MASK) begin
            tcount_r <= '0;
            closed_r <= 1'b0;
            done_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/topic_filter_match_engine.sv =====
// top level of the topic filter match engine
// depends on tfme_pkg, tfme_ctrl, tfme_datapath
// An accepted topic byte that extends the topic holds in_tready low during a sweep over
// all filter slots: each slot takes a store read, a filter byte read and an evaluate step,
// repeated for each further filter byte a '/' topic byte lets it consume after a '+'.
// Topic end runs the same sweep to build the client mask, a further step moves it to the
// output register, and in_tready stays low until that result item is taken. Filter byte
// and owner writes can follow back to back. No clearing pass.
module topic_filter_match_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0] slot[7:2] position[14:8] owner_client[19:15] slot_enable[20]
  // byte_value[28:21]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // client_mask[31:0] matched_any[32]
  output logic [39:0] out_tdata
);
  tfme_pkg::ctl_cmd_t cmd;
  tfme_pkg::dp_stat_t stat;
  logic busy, done, in_fire;
  logic [31:0] mask;
  logic ov_r;
  logic [31:0] omask_r;
  logic [7:0] tbyte_r;

  assign in_tready = !busy && !ov_r;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) tbyte_r <= in_tdata[28:21];
  end

  tfme_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .op(in_tdata[1:0]), .slot(in_tdata[7:2]),
    .byte_in(in_tdata[28:21]), .stat, .busy, .cmd, .done
  );

  tfme_datapath u_dp (
    .clk, .rst_n, .cmd, .wr_slot(in_tdata[7:2]), .wr_pos(in_tdata[14:8]),
    .wr_owner(in_tdata[19:15]), .wr_en_bit(in_tdata[20]), .wr_byte(in_tdata[28:21]),
    .topic_byte(tbyte_r), .mask, .stat
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) omask_r <= mask;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, omask_r != 32'd0, omask_r};
endmodule

// ===== sv/tfme_checker.sv =====
// port-level checker of the topic filter match engine, bound to the top level
// depends on topic_filter_match_engine ports and tfme_pkg
module tfme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  a_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32] == (out_tdata[31:0] != 32'd0)) else $error("matched_any");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_tbusy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == tfme_pkg::OP_TEND |=> !in_tready)
    else $error("busy");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("in while out");
endmodule

bind topic_filter_match_engine tfme_checker u_chk (.*);

// ===== tb/sv/tb_topic_filter_match_engine.sv =====
// testbench of the topic filter match engine: directed and random filter/topic traffic
// predicts the client mask per topic end and checks each out item; depends on tfme_pkg
`timescale 1ns / 1ps

class match_scoreboard;
  logic [7:0] fbytes [tfme_pkg::SLOTS*tfme_pkg::FILTER_LEN];
  bit         svalid [tfme_pkg::SLOTS];
  logic [4:0] sowner [tfme_pkg::SLOTS];
  int         cursor [tfme_pkg::SLOTS];
  tfme_pkg::mstat_t mstat [tfme_pkg::SLOTS];
  int         tcount;
  bit         tclosed;
  logic [32:0] pending_masks[$];
  int         mismatches;
  int         results_seen;

  function new();
    foreach (fbytes[i]) fbytes[i] = 8'h00;
    foreach (svalid[i]) begin
      svalid[i] = 0;
      sowner[i] = 0;
    end
    rearm_all();
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void rearm_all();
    foreach (cursor[i]) begin
      cursor[i] = 0;
      mstat[i] = tfme_pkg::ST_RUN;
    end
    tcount = 0;
    tclosed = 0;
  endfunction

  function logic [7:0] filter_at(int s, int p);
    if (p >= tfme_pkg::FILTER_LEN - 1) return 8'h00;
    return fbytes[s*tfme_pkg::FILTER_LEN + p];
  endfunction

  function void advance(int s, logic [7:0] c);
    logic [7:0] f;
    for (int g = 0; g < 2*tfme_pkg::FILTER_LEN + 4; g++) begin
      if (mstat[s] == tfme_pkg::ST_SKIP) begin
        if (c != tfme_pkg::CH_LEVEL) return;
        mstat[s] = tfme_pkg::ST_RUN;
        continue;
      end
      if (mstat[s] != tfme_pkg::ST_RUN) return;
      f = filter_at(s, cursor[s]);
      if (f == 8'h00) begin
        mstat[s] = tfme_pkg::ST_MISS;
        return;
      end
      if (f == tfme_pkg::CH_MULTI) begin
        mstat[s] = tfme_pkg::ST_HIT;
        return;
      end
      if (f == tfme_pkg::CH_SINGLE) begin
        cursor[s]++;
        mstat[s] = tfme_pkg::ST_SKIP;
        continue;
      end
      if (f != c) begin
        mstat[s] = tfme_pkg::ST_MISS;
        return;
      end
      cursor[s]++;
      return;
    end
    mstat[s] = tfme_pkg::ST_MISS;
  endfunction

  // returns 1 when the item causes a result
  function bit note_input(logic [31:0] d);
    logic [1:0] op;
    int slot, pos;
    logic [7:0] b;
    logic [31:0] mask;
    logic [7:0] f;
    bit hit;
    op = d[1:0];
    slot = d[7:2];
    pos = d[14:8];
    b = d[28:21];
    case (op)
      tfme_pkg::OP_FBYTE: fbytes[slot*tfme_pkg::FILTER_LEN + pos] = b;
      tfme_pkg::OP_OWNER: begin
        sowner[slot] = d[19:15];
        svalid[slot] = d[20];
      end
      tfme_pkg::OP_TBYTE: begin
        if (!tclosed) begin
          if (b == 8'h00) tclosed = 1;
          else if (tcount < tfme_pkg::TOPIC_MAX) begin
            tcount++;
            for (int s = 0; s < tfme_pkg::SLOTS; s++) advance(s, b);
          end
        end
      end
      default: begin
        mask = 0;
        for (int s = 0; s < tfme_pkg::SLOTS; s++) begin
          if (mstat[s] == tfme_pkg::ST_HIT) hit = 1;
          else if (mstat[s] == tfme_pkg::ST_MISS) hit = 0;
          else begin
            f = filter_at(s, cursor[s]);
            hit = (f == tfme_pkg::CH_MULTI) || (f == 8'h00);
          end
          if (svalid[s] && sowner[s] < tfme_pkg::CLIENTS && hit) mask[sowner[s]] = 1'b1;
        end
        pending_masks.push_back({mask != 0, mask});
        rearm_all();
        return 1;
      end
    endcase
    return 0;
  endfunction

  function void check_result(logic [39:0] d);
    logic [32:0] exp_r;
    results_seen++;
    if (pending_masks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", d);
      return;
    end
    exp_r = pending_masks.pop_front();
    if (d[31:0] !== exp_r[31:0] || d[32] !== exp_r[32]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: mask exp %h got %h, any exp %b got %b",
                 exp_r[31:0], d[31:0], exp_r[32], d[32]);
    end
  endfunction
endclass

module tb_topic_filter_match_engine;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;

  match_scoreboard sb;
  bit   no_idle = 0;
  int   cycles = 0;
  int   items_sent = 0;
  int   topics_sent = 0;
  localparam int CYCLE_LIMIT = 900000;

  topic_filter_match_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("topic_filter_match_engine: mismatch");
      $finish;
    end
  end

  // result side: random stall, check on handshake
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
  end

  function automatic logic [31:0] pack_item(logic [1:0] op, int slot, int pos, int owner,
      int en, int b);
    return {3'b000, b[7:0], en[0], owner[4:0], pos[6:0], slot[5:0], op};
  endfunction

  // in_tvalid stays high after an accept so items can follow back to back
  task automatic send_item(logic [31:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 29) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(sb.note_input(d));
    items_sent++;
    if (d[1:0] == tfme_pkg::OP_TEND) topics_sent++;
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_filter(int slot, string text);
    for (int i = 0; i < text.len(); i++)
      send_item(pack_item(tfme_pkg::OP_FBYTE, slot, i, $urandom, $urandom, text[i]));
    send_item(pack_item(tfme_pkg::OP_FBYTE, slot, text.len(), $urandom, $urandom, 0));
  endtask

  task automatic send_bytes(string text);
    for (int i = 0; i < text.len(); i++)
      send_item(pack_item(tfme_pkg::OP_TBYTE, $urandom, $urandom, $urandom, $urandom,
                          text[i]));
  endtask

  task automatic send_end();
    send_item(pack_item(tfme_pkg::OP_TEND, $urandom, $urandom, $urandom, $urandom,
                        $urandom));
  endtask

  task automatic send_topic(string text);
    send_bytes(text);
    send_end();
  endtask

  task automatic wait_drained();
    while (sb.pending_masks.size() != 0) @(posedge clk);
  endtask

  function automatic string rand_level();
    string s;
    int n;
    s = "";
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'h61 + $urandom_range(2));
    return s;
  endfunction

  function automatic string rand_text(bit as_filter);
    string s;
    int lv;
    int r;
    s = "";
    lv = $urandom_range(1, 4);
    for (int i = 0; i < lv; i++) begin
      if (i) s = {s, "/"};
      r = $urandom_range(9);
      if (as_filter && r == 0) s = {s, "+"};
      else if (as_filter && r == 1) begin
        s = {s, "#"};
        break;
      end else s = {s, rand_level()};
    end
    return s;
  endfunction

  task automatic random_noise();
    logic [31:0] d;
    d = $urandom;
    d[31:29] = 0;
    // noise never writes filter bytes, so every filter stays terminated
    if (d[1:0] == tfme_pkg::OP_FBYTE) d[1:0] = tfme_pkg::OP_TBYTE;
    send_item(d);
  endtask

  initial begin
    string longstr;
    int slot;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every slot gets a defined filter so any cursor read is written
    no_idle = 1;
    for (int s = 0; s < tfme_pkg::SLOTS; s++)
      send_item(pack_item(tfme_pkg::OP_FBYTE, s, 0, 0, 0, 0));
    write_filter(0, "a/b");
    write_filter(1, "a/+");
    write_filter(2, "#");
    write_filter(3, "+/#");
    write_filter(63, "a/#/x");
    send_item(pack_item(tfme_pkg::OP_OWNER, 0, 0, 0, 1, 0));
    send_item(pack_item(tfme_pkg::OP_OWNER, 1, 0, 31, 1, 0));
    send_item(pack_item(tfme_pkg::OP_OWNER, 2, 0, 5, 1, 0));
    send_item(pack_item(tfme_pkg::OP_OWNER, 63, 0, 17, 1, 0));
    send_item(pack_item(tfme_pkg::OP_OWNER, 4, 0, 9, 1, 0));   // empty filter
    no_idle = 0;
    send_topic("a/b");
    send_topic("");                                  // empty topic
    send_bytes("a/");
    send_item(pack_item(tfme_pkg::OP_TBYTE, 0, 0, 0, 0, 8'hff));
    send_end();
    // zero byte ends topic early
    send_bytes("a/b");
    send_item(pack_item(tfme_pkg::OP_TBYTE, 0, 0, 0, 0, 0));
    send_topic("zz");
    send_item(pack_item(tfme_pkg::OP_OWNER, 2, 0, 5, 0, 0));
    // filter reaching the row's last byte, topic beyond the topic limit
    for (int i = 0; i < tfme_pkg::FILTER_LEN; i++)
      send_item(pack_item(tfme_pkg::OP_FBYTE, 5, i, 0, 0,
                          (i == tfme_pkg::FILTER_LEN - 1) ? 8'hff : 8'h61));
    send_item(pack_item(tfme_pkg::OP_OWNER, 5, 0, 3, 1, 0));
    longstr = "";
    for (int i = 0; i < 130; i++) longstr = {longstr, "a"};
    send_topic(longstr);
    idle_input();
    wait_drained();

    // random: mostly well-formed filters and topics
    while (items_sent < 540) begin
      int r;
      r = $urandom_range(99);
      if (items_sent > 420 && items_sent < 480) no_idle = 1;
      else no_idle = 0;
      if (r < 15) begin
        slot = $urandom_range(tfme_pkg::SLOTS - 1);
        write_filter(slot, rand_text(1));
      end else if (r < 30) begin
        send_item(pack_item(tfme_pkg::OP_OWNER, $urandom, 0, $urandom,
                            $urandom_range(99) < 75, $urandom));
      end else if (r < 85) begin
        send_topic(rand_text(0));
      end else begin
        random_noise();
      end
    end
    send_item(pack_item(tfme_pkg::OP_TEND, 0, 0, 0, 0, 0));
    idle_input();
    wait_drained();
    repeat (2 * tfme_pkg::SLOTS + 10) @(posedge clk);

    $display("sent %0d items with %0d topic ends, checked %0d results",
             items_sent, topics_sent, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending_masks.size() == 0)
      $display("topic_filter_match_engine: match");
    else
      $display("topic_filter_match_engine: mismatch");
    $finish;
  end
endmodule
